>>> design/sgtr_pkg.sv
// Shared constants, types and the control-store program for the glyph rasterizer.
`timescale 1ns / 1ps

package sgtr_pkg;

    // Default geometry of the font cell
    localparam int GLYPH_COLS_DEF   = 5;
    localparam int GLYPH_ROWS_DEF   = 8;
    localparam int CELL_ADVANCE_DEF = 6;

    // Fixed limits
    localparam int RESULT_LIMIT = 40;
    localparam int COORD_LIMIT  = 4096;
    localparam int PITCH_LIMIT  = 8192;
    localparam int PEN_MAX      = 32767;
    localparam int SCALE_MAX    = 15;

    // Field widths
    localparam int PEN_W    = 16;
    localparam int SCALE_W  = 4;
    localparam int COLOR_W  = 32;
    localparam int RECT_XY_W = 12;
    localparam int RECT_WH_W = 4;
    localparam int ADDR_W   = 26;
    localparam int DIM_W    = 13;
    localparam int PITCH_W  = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int COORD_W  = 18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 14'd640;

    // Microprogram
    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_SCAN,
        STEP_FLUSH,
        STEP_ADVANCE
    } step_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SCAN,
        OP_FLUSH,
        OP_ADVANCE
    } op_t;

    typedef enum logic [1:0] {
        COND_ACCEPT,
        COND_SCAN_END,
        COND_FLUSHED,
        COND_ALWAYS
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
    } ctrl_word_t;

    // Control store: a step holds until its condition is met, then jumps
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:    w = '{op: OP_LOAD,    cond: COND_ACCEPT,   jump: STEP_SCAN};
            STEP_SCAN:    w = '{op: OP_SCAN,    cond: COND_SCAN_END, jump: STEP_FLUSH};
            STEP_FLUSH:   w = '{op: OP_FLUSH,   cond: COND_FLUSHED,  jump: STEP_ADVANCE};
            STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: COND_ALWAYS,   jump: STEP_IDLE};
            default:      w = '{op: OP_LOAD,    cond: COND_ALWAYS,   jump: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> design/sgtr_text_if.sv
// Character input channel: valid/ready handshake with the character payload.
`timescale 1ns / 1ps

interface sgtr_text_if #(
    parameter int GLYPH_COLS = sgtr_pkg::GLYPH_COLS_DEF
);
    import sgtr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          start_text;
    logic signed [PEN_W-1:0]       start_x;
    logic signed [PEN_W-1:0]       start_y;
    logic [SCALE_W-1:0]            char_scale;
    logic [8*GLYPH_COLS-1:0]       glyph_columns;
    logic [COLOR_W-1:0]            ink_color;

    modport source (
        output valid, start_text, start_x, start_y, char_scale, glyph_columns, ink_color,
        input  ready
    );

    modport sink (
        input  valid, start_text, start_x, start_y, char_scale, glyph_columns, ink_color,
        output ready
    );
endinterface

>>> design/sgtr_rect_if.sv
// Rectangle output channel: valid/ready handshake with the fill rectangle payload.
`timescale 1ns / 1ps

interface sgtr_rect_if;
    import sgtr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RECT_XY_W-1:0]  rect_x;
    logic [RECT_XY_W-1:0]  rect_y;
    logic [RECT_WH_W-1:0]  rect_w;
    logic [RECT_WH_W-1:0]  rect_h;
    logic [ADDR_W-1:0]     start_address;
    logic [COLOR_W-1:0]    rect_color;
    logic                  last_rect;

    modport source (
        output valid, rect_x, rect_y, rect_w, rect_h, start_address, rect_color, last_rect,
        input  ready
    );

    modport sink (
        input  valid, rect_x, rect_y, rect_w, rect_h, start_address, rect_color, last_rect,
        output ready
    );
endinterface

>>> design/scaled_glyph_text_rasterizer.sv
// Scaled glyph text rasterizer: turns one glyph bitmap per transaction into clipped fill rectangles.
`timescale 1ns / 1ps

// Each input transaction carries one character as GLYPH_COLS columns of eight
// bits (bit 0 at the top); start_text first loads pen x/y and the scale (0 taken
// as 1). Every set bit yields one scale-by-scale cell, clipped to the screen,
// and each surviving cell leaves as one rectangle transaction, columns outer and
// rows inner, the last one of the character flagged by last_rect; at most 40 per
// character. Afterwards pen x advances by CELL_ADVANCE*scale, saturating at 32767.
// A small control store steps the datapath: one cell is examined per clock while
// the scan runs, except when a new hit finds a rectangle already held back and
// the rectangle sink holds ready low on the output register; then the scan stalls.
// Cells pass the single clip unit; a load step precedes the scan, flush and advance follow.
// The rectangle output is registered and one further rectangle is held back, so
// that the last one can be marked. The next character is taken while the final
// rectangle of the previous one still waits in the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// meant to be made only while the block is idle.

module scaled_glyph_text_rasterizer #(
    parameter int GLYPH_COLS   = sgtr_pkg::GLYPH_COLS_DEF,
    parameter int GLYPH_ROWS   = sgtr_pkg::GLYPH_ROWS_DEF,
    parameter int CELL_ADVANCE = sgtr_pkg::CELL_ADVANCE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sgtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sgtr_pkg::CFG_DATA_W-1:0]  cfg_data,
    sgtr_text_if.sink                        text_in,
    sgtr_rect_if.source                      rect_out
);
    import sgtr_pkg::*;

    localparam int GW      = 8 * GLYPH_COLS;
    localparam int COL_W   = $clog2(GLYPH_COLS + 1);
    localparam int ROW_W   = $clog2(GLYPH_ROWS + 1);
    localparam int OFF_MAX = ((GLYPH_COLS > GLYPH_ROWS) ? GLYPH_COLS : GLYPH_ROWS) * SCALE_MAX;
    localparam int OFF_W   = $clog2(OFF_MAX + 1);
    localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);

    // Sequencer
    step_t      step_reg, step_next;
    ctrl_word_t ctrl;
    logic       cond_true;

    // Configuration
    logic [DIM_W-1:0]   scr_w_reg, scr_w_next;
    logic [DIM_W-1:0]   scr_h_reg, scr_h_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;

    // Pen state
    logic signed [PEN_W-1:0] pen_x_reg, pen_x_next;
    logic signed [PEN_W-1:0] pen_y_reg, pen_y_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;

    // Scan state
    logic [GW-1:0]      glyph_reg, glyph_next;
    logic [7:0]         col_bits_reg, col_bits_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [COL_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [OFF_W-1:0]   col_off_reg, col_off_next;
    logic [OFF_W-1:0]   row_off_reg, row_off_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Held-back rectangle
    logic                 pend_valid_reg, pend_valid_next;
    logic [RECT_XY_W-1:0] pend_x_reg, pend_x_next;
    logic [RECT_XY_W-1:0] pend_y_reg, pend_y_next;
    logic [RECT_WH_W-1:0] pend_w_reg, pend_w_next;
    logic [RECT_WH_W-1:0] pend_h_reg, pend_h_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [RECT_XY_W-1:0] out_x_reg, out_x_next;
    logic [RECT_XY_W-1:0] out_y_reg, out_y_next;
    logic [RECT_WH_W-1:0] out_w_reg, out_w_next;
    logic [RECT_WH_W-1:0] out_h_reg, out_h_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0]   out_color_reg, out_color_next;
    logic                 out_last_reg, out_last_next;

    // Clip datapath
    logic [DIM_W-1:0]          wlim, hlim;
    logic [PITCH_W-1:0]        pitch_lim;
    logic signed [COORD_W-1:0] pen_x_s, pen_y_s, col_off_s, row_off_s, scale_s;
    logic signed [COORD_W-1:0] wlim_s, hlim_s;
    logic signed [COORD_W-1:0] cx, cy, x0, y0, x1, y1, x1_raw, y1_raw;
    logic signed [COORD_W-1:0] adv, pen_max_s;
    logic [COORD_W-1:0]        x_span, y_span;
    logic                      cell_vis, cell_hit, out_busy, last_row, last_cell;
    logic                      scan_stall, limit_hit, in_take;
    logic [SCALE_W-1:0]        load_scale;

    assign ctrl = ucode_rom(step_reg);

    assign wlim      = (scr_w_reg > DIM_W'(COORD_LIMIT)) ? DIM_W'(COORD_LIMIT) : scr_w_reg;
    assign hlim      = (scr_h_reg > DIM_W'(COORD_LIMIT)) ? DIM_W'(COORD_LIMIT) : scr_h_reg;
    assign pitch_lim = (pitch_reg > PITCH_W'(PITCH_LIMIT)) ? PITCH_W'(PITCH_LIMIT) : pitch_reg;

    assign pen_x_s   = COORD_W'(pen_x_reg);
    assign pen_y_s   = COORD_W'(pen_y_reg);
    assign col_off_s = signed'(COORD_W'(col_off_reg));
    assign row_off_s = signed'(COORD_W'(row_off_reg));
    assign scale_s   = signed'(COORD_W'(scale_reg));
    assign wlim_s    = signed'(COORD_W'(wlim));
    assign hlim_s    = signed'(COORD_W'(hlim));
    assign pen_max_s = signed'(COORD_W'(PEN_MAX));

    // Current cell, intersected with the screen
    assign cx     = pen_x_s + col_off_s;
    assign cy     = pen_y_s + row_off_s;
    assign x1_raw = cx + scale_s;
    assign y1_raw = cy + scale_s;
    assign x0     = cx[COORD_W-1] ? '0 : cx;
    assign y0     = cy[COORD_W-1] ? '0 : cy;
    assign x1     = (x1_raw > wlim_s) ? wlim_s : x1_raw;
    assign y1     = (y1_raw > hlim_s) ? hlim_s : y1_raw;
    assign x_span = COORD_W'(x1 - x0);
    assign y_span = COORD_W'(y1 - y0);

    assign cell_vis  = (x1 > x0) && (y1 > y0);
    assign limit_hit = (count_reg == CNT_W'(RESULT_LIMIT));
    assign cell_hit  = col_bits_reg[0] && cell_vis && !limit_hit;
    assign out_busy  = out_valid_reg && !rect_out.ready;
    // A new hit must push the held rectangle out first
    assign scan_stall = cell_hit && pend_valid_reg && out_busy;
    assign last_row   = (row_cnt_reg == ROW_W'(GLYPH_ROWS - 1));
    assign last_cell  = last_row && (col_cnt_reg == COL_W'(GLYPH_COLS - 1));

    assign adv = pen_x_s + signed'(COORD_W'(scale_reg * CELL_ADVANCE));

    assign in_take    = (ctrl.op == OP_LOAD) && text_in.valid;
    assign load_scale = (text_in.char_scale == '0) ? SCALE_W'(1) : text_in.char_scale;

    always_comb
    begin
        case (ctrl.cond)
            COND_ACCEPT:   cond_true = text_in.valid;
            COND_SCAN_END: cond_true = limit_hit || (last_cell && !scan_stall);
            COND_FLUSHED:  cond_true = !pend_valid_reg || !out_busy;
            COND_ALWAYS:   cond_true = 1'b1;
            default:       cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next       = cond_true ? ctrl.jump : step_reg;
        scr_w_next      = scr_w_reg;
        scr_h_next      = scr_h_reg;
        pitch_next      = pitch_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        scale_next      = scale_reg;
        glyph_next      = glyph_reg;
        col_bits_next   = col_bits_reg;
        color_next      = color_reg;
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        col_off_next    = col_off_reg;
        row_off_next    = row_off_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_w_next     = pend_w_reg;
        pend_h_next     = pend_h_reg;
        out_valid_next  = out_valid_reg && !rect_out.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_w_next      = out_w_reg;
        out_h_next      = out_h_reg;
        out_addr_next   = out_addr_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  scr_w_next = cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: scr_h_next = cfg_data[DIM_W-1:0];
                CFG_ROW_PITCH:     pitch_next = cfg_data[PITCH_W-1:0];
                default:           ;
            endcase
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_take)
                begin
                    glyph_next    = GW'(text_in.glyph_columns);
                    col_bits_next = glyph_next[7:0];
                    color_next    = text_in.ink_color;
                    col_cnt_next  = '0;
                    row_cnt_next  = '0;
                    col_off_next  = '0;
                    row_off_next  = '0;
                    count_next    = '0;
                    if (text_in.start_text)
                    begin
                        pen_x_next = text_in.start_x;
                        pen_y_next = text_in.start_y;
                        scale_next = load_scale;
                    end
                end
            end
            OP_SCAN:
            begin
                if (!scan_stall && !limit_hit)
                begin
                    if (cell_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = x0[RECT_XY_W-1:0];
                        pend_y_next     = y0[RECT_XY_W-1:0];
                        pend_w_next     = x_span[RECT_WH_W-1:0];
                        pend_h_next     = y_span[RECT_WH_W-1:0];
                        count_next      = count_reg + CNT_W'(1);
                    end
                    if (last_row)
                    begin
                        row_cnt_next  = '0;
                        row_off_next  = '0;
                        col_cnt_next  = col_cnt_reg + COL_W'(1);
                        col_off_next  = col_off_reg + OFF_W'(scale_reg);
                        glyph_next    = glyph_reg >> 8;
                        col_bits_next = glyph_next[7:0];
                    end
                    else
                    begin
                        row_cnt_next  = row_cnt_reg + ROW_W'(1);
                        row_off_next  = row_off_reg + OFF_W'(scale_reg);
                        col_bits_next = col_bits_reg >> 1;
                    end
                end
            end
            OP_FLUSH:
            begin
                if (pend_valid_reg && !out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            OP_ADVANCE:
            begin
                pen_x_next = (adv > pen_max_s) ? PEN_W'(PEN_MAX) : adv[PEN_W-1:0];
            end
            default: ;
        endcase

        // Load the output register from the held rectangle
        if (out_valid_next && !(out_valid_reg && !rect_out.ready))
        begin
            out_x_next     = pend_x_reg;
            out_y_next     = pend_y_reg;
            out_w_next     = pend_w_reg;
            out_h_next     = pend_h_reg;
            out_addr_next  = ADDR_W'(pend_y_reg) * ADDR_W'(pitch_lim) + ADDR_W'(pend_x_reg);
            out_color_next = color_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            scr_w_reg      <= SCREEN_WIDTH_RST;
            scr_h_reg      <= SCREEN_HEIGHT_RST;
            pitch_reg      <= ROW_PITCH_RST;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            scale_reg      <= SCALE_W'(1);
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            col_off_reg    <= '0;
            row_off_reg    <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            scr_w_reg      <= scr_w_next;
            scr_h_reg      <= scr_h_next;
            pitch_reg      <= pitch_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            scale_reg      <= scale_next;
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            col_off_reg    <= col_off_next;
            row_off_reg    <= row_off_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        col_bits_reg  <= col_bits_next;
        color_reg     <= color_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        pend_w_reg    <= pend_w_next;
        pend_h_reg    <= pend_h_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_w_reg     <= out_w_next;
        out_h_reg     <= out_h_next;
        out_addr_reg  <= out_addr_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign text_in.ready          = (ctrl.op == OP_LOAD);
    assign rect_out.valid         = out_valid_reg;
    assign rect_out.rect_x        = out_x_reg;
    assign rect_out.rect_y        = out_y_reg;
    assign rect_out.rect_w        = out_w_reg;
    assign rect_out.rect_h        = out_h_reg;
    assign rect_out.start_address = out_addr_reg;
    assign rect_out.rect_color    = out_color_reg;
    assign rect_out.last_rect     = out_last_reg;

endmodule

>>> design/sgtr_checker.sv
// Port-level checks for the glyph rasterizer, bound to the top level.
`timescale 1ns / 1ps

module sgtr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [sgtr_pkg::RECT_XY_W-1:0]      rect_x,
    input logic [sgtr_pkg::RECT_WH_W-1:0]      rect_w,
    input logic [sgtr_pkg::RECT_WH_W-1:0]      rect_h,
    input logic [sgtr_pkg::ADDR_W-1:0]         start_address,
    input logic                                last_rect
);
    import sgtr_pkg::*;

    // A shown rectangle is never empty and never runs past the coordinate limit on the right
    a_rect_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rect_w != '0) && (rect_h != '0)
                      && ((DIM_W'(rect_x) + DIM_W'(rect_w)) <= DIM_W'(COORD_LIMIT)))
        else $error("rectangle empty or beyond screen limit");

    // A character is being scanned right after it is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again without scanning");

    // After a rectangle that is not the last of its character has left, no new character is taken
    a_char_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_rect) |=> !in_ready)
        else $error("new character accepted before last rectangle");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(start_address) && $stable(last_rect))
        else $error("stalled rectangle changed");

endmodule

bind scaled_glyph_text_rasterizer sgtr_checker u_sgtr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (text_in.valid),
    .in_ready      (text_in.ready),
    .out_valid     (rect_out.valid),
    .out_ready     (rect_out.ready),
    .rect_x        (rect_out.rect_x),
    .rect_w        (rect_out.rect_w),
    .rect_h        (rect_out.rect_h),
    .start_address (rect_out.start_address),
    .last_rect     (rect_out.last_rect)
);
